/* hdl/wildcard_byte_pattern_search_macros.svh */
// Assertion macros for the wildcard byte pattern search block.
// Included by the top level; expects a clock and an active-low reset name.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define WBPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wbps assertion failed");

// Next-cycle implication, disabled during reset.
`define WBPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wbps assertion failed");

`endif

/* hdl/wbps_pkg.sv */
// Shared types and constants for the wildcard byte pattern search block.
// No dependencies.
`default_nettype none

package wbps_pkg;

    localparam int MAX_PATTERN = 16;   // window depth, 1..64
    localparam int OFFSET_BITS = 32;   // byte counter width, 8..64
    localparam int REG_BYTES   = 16;   // pattern bytes held by the registers
    localparam int CMP_BYTES   = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
    localparam int LEN_W       = 5;
    localparam int OUT_W       = 32;
    localparam int CFG_W       = 64;
    localparam int WIN_IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    typedef enum logic [1:0] {
        CFG_PAT_LO = 2'd0,
        CFG_PAT_HI = 2'd1,
        CFG_WILD   = 2'd2,
        CFG_LEN    = 2'd3
    } t_cfg_idx;

    typedef logic [MAX_PATTERN-1:0][7:0] t_win;
    typedef logic [OFFSET_BITS-1:0]      t_count;

    typedef struct packed {
        logic [REG_BYTES-1:0][7:0] pat;
        logic [REG_BYTES-1:0]      wild;
        logic [LEN_W-1:0]          len;
    } t_cfg;

endpackage

`default_nettype wire

/* hdl/wildcard_byte_pattern_search.sv */
// Top level of the wildcard byte pattern search block.
// Depends on wbps_pkg, wbps_cfg, wbps_match and wildcard_byte_pattern_search_macros.svh.
//
// Usage:
//   Bytes of a buffer enter on the input channel (i_in_valid / o_in_ready),
//   one request per byte, with i_last_byte set on the final byte. Each buffer
//   yields exactly one result request on the output channel: found=1 with
//   the start offset at the first match, or found=0, offset 0 at the last
//   byte when nothing matched. Bytes after a match give no further result.
//   Configuration (pattern bytes, wildcard mask, length) is written through
//   i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// Timing:
//   One byte per cycle sustained unless a stalled result holds intake. A byte
//   is registered on accept, compared in the next cycle (16 masked byte
//   compares, counter subtract), and its result is registered for output.
// Reset:
//   Synchronous, active low. Clears registers, window, byte count, flags.
// Stall:
//   A held result keeps its request; bytes that make no result still pass,
//   and intake stops only when a result-making byte finds the register full.
`default_nettype none

`include "wildcard_byte_pattern_search_macros.svh"

module wildcard_byte_pattern_search (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration write port
    input  wire logic                       i_cfg_we,
    input  wire logic [1:0]                 i_cfg_idx,
    input  wire logic [wbps_pkg::CFG_W-1:0] i_cfg_data,
    // byte input channel
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [7:0]                 i_data_byte,
    input  wire logic                       i_last_byte,
    // result channel
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic                            o_found,
    output logic [wbps_pkg::OUT_W-1:0]      o_match_offset
);
    import wbps_pkg::*;

    t_cfg cfg;

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // scan state
    t_win   r_win;
    t_count r_count;
    logic   r_rep;
    t_win   n_win;
    t_count n_count;

    // result register
    logic             r_out_vld;
    logic             r_out_found;
    logic [OUT_W-1:0] r_out_off;

    logic             hit;
    logic [OUT_W-1:0] hit_off;
    logic             produce;
    logic             adv;
    logic             in_acc;

    wbps_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Window after shifting in the staged byte; count saturates at all ones.
    always_comb begin
        n_win[0] = r_in_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win[k] = r_win[k-1];
        end
        n_count = (r_count == '1) ? r_count : r_count + OFFSET_BITS'(1);
    end

    wbps_match u_match (
        .i_cfg    (cfg),
        .i_win    (n_win),
        .i_count  (n_count),
        .o_hit    (hit),
        .o_offset (hit_off)
    );

    // A staged byte makes a result on its first match, or at buffer end.
    assign produce    = !r_rep && (hit || r_in_last);
    assign adv        = r_in_vld && (!produce || !r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_in_byte <= '0;
            r_in_last <= 1'b0;
        end else if (in_acc) begin
            r_in_vld  <= 1'b1;
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end else if (adv) begin
            r_in_vld  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_count <= '0;
            r_rep   <= 1'b0;
        end else if (adv) begin
            if (r_in_last) begin
                // buffer done: fresh state for the next one
                r_win   <= '0;
                r_count <= '0;
                r_rep   <= 1'b0;
            end else begin
                r_win   <= n_win;
                r_count <= n_count;
                r_rep   <= r_rep || hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_out_found <= 1'b0;
            r_out_off   <= '0;
        end else if (adv && produce) begin
            r_out_vld   <= 1'b1;
            r_out_found <= hit;
            r_out_off   <= hit ? hit_off : '0;
        end else if (i_out_ready) begin
            r_out_vld   <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_found        = r_out_found;
    assign o_match_offset = r_out_off;

    // Intake never blocks while the result register is empty.
    `WBPS_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !r_out_vld, o_in_ready)
    // The last byte of a buffer leaves a cleared count and flag behind.
    `WBPS_ASSERT_NEXT(a_clear_on_last, i_clk, i_rst_n, adv && r_in_last, (r_count == '0) && !r_rep)
    // A reported match mid-buffer blocks further results.
    `WBPS_ASSERT_NEXT(a_rep_after_hit, i_clk, i_rst_n, adv && produce && hit && !r_in_last, r_rep)

endmodule

`default_nettype wire

/* hdl/wbps_cfg.sv */
// Configuration register file for the pattern search.
// Depends on wbps_pkg.
`default_nettype none

module wbps_cfg (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [1:0]                i_cfg_idx,
    input  wire logic [wbps_pkg::CFG_W-1:0] i_cfg_data,
    output wbps_pkg::t_cfg                 o_cfg
);
    import wbps_pkg::*;

    logic [CFG_W-1:0]     r_pat_lo;
    logic [CFG_W-1:0]     r_pat_hi;
    logic [REG_BYTES-1:0] r_wild;
    logic [LEN_W-1:0]     r_len;
    t_cfg_idx             idx;

    assign idx = t_cfg_idx'(i_cfg_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_lo <= '0;
            r_pat_hi <= '0;
            r_wild   <= '0;
            r_len    <= '0;
        end else if (i_cfg_we) begin
            case (idx)
                CFG_PAT_LO: r_pat_lo <= i_cfg_data;
                CFG_PAT_HI: r_pat_hi <= i_cfg_data;
                CFG_WILD:   r_wild   <= i_cfg_data[REG_BYTES-1:0];
                CFG_LEN:    r_len    <= i_cfg_data[LEN_W-1:0];
                default:    ;
            endcase
        end
    end

    assign o_cfg.pat  = {r_pat_hi, r_pat_lo};
    assign o_cfg.wild = r_wild;
    assign o_cfg.len  = r_len;

endmodule

`default_nettype wire

/* hdl/wbps_match.sv */
// Masked parallel compare of the byte window against the pattern.
// Depends on wbps_pkg.
`default_nettype none

module wbps_match (
    input  wbps_pkg::t_cfg              i_cfg,
    input  wbps_pkg::t_win              i_win,
    input  wbps_pkg::t_count            i_count,
    output logic                        o_hit,
    output logic [wbps_pkg::OUT_W-1:0]  o_offset
);
    import wbps_pkg::*;

    logic             len_ok;
    logic             enough;
    logic [CMP_BYTES-1:0] byte_ok;
    logic [LEN_W-1:0] pos [CMP_BYTES];

    assign len_ok = (i_cfg.len != '0) && (i_cfg.len <= LEN_W'(CMP_BYTES));
    assign enough = (i_count >= OFFSET_BITS'(i_cfg.len));

    // Pattern byte j lines up with window slot len-1-j (newest byte in slot 0).
    always_comb begin
        for (int j = 0; j < CMP_BYTES; j++) begin
            pos[j]     = i_cfg.len - LEN_W'(1) - LEN_W'(j);
            byte_ok[j] = (LEN_W'(j) >= i_cfg.len) || i_cfg.wild[j] ||
                         (i_win[WIN_IDX_W'(pos[j])] == i_cfg.pat[j]);
        end
    end

    assign o_hit    = len_ok && enough && (&byte_ok);
    assign o_offset = OUT_W'(i_count - OFFSET_BITS'(i_cfg.len));

endmodule

`default_nettype wire
